>>> hdl/qrs_pkg.sv
// Shared widths, result codes and word types of the quadratic root solver.
`timescale 1ns / 1ps
package qrs_pkg;

   localparam int QRS_FRAC_BITS = 16;
   localparam int COEF_W        = 32;
   localparam int VAL_W         = 32;
   localparam int KIND_W        = 3;
   localparam int DISC_W        = 2 * COEF_W + 2;
   localparam int ROOT_W        = 34;
   localparam int RAD_W         = 2 * ROOT_W;
   localparam int SREM_W        = ROOT_W + 3;
   localparam int NUM_MAG_W     = 34;
   localparam int NSUM_W        = NUM_MAG_W + 2;
   localparam int DEN_W         = COEF_W + 1;
   localparam int FRONT_STAGES  = 3;

   typedef logic [KIND_W-1:0] kind_type;

   localparam kind_type KIND_ANY     = 3'd0;
   localparam kind_type KIND_NONE    = 3'd1;
   localparam kind_type KIND_LINEAR  = 3'd2;
   localparam kind_type KIND_DOUBLE  = 3'd3;
   localparam kind_type KIND_COMPLEX = 3'd4;
   localparam kind_type KIND_TWO     = 3'd5;

   typedef struct packed {
      logic signed [COEF_W-1:0] a;
      logic signed [COEF_W-1:0] b;
      logic signed [COEF_W-1:0] c;
      logic                     dneg;
      logic                     dzero;
   } front_type;

   typedef struct packed {
      kind_type kind;
      logic     neg;
   } div_tag_type;

endpackage

>>> hdl/quadratic_root_solver.sv
// Quadratic root solver for a*x^2 + b*x + c = 0 on signed Q16.16 coefficients.
// One coefficient word enters per cycle while req_tready is high, and one result
// word leaves per cycle while rsp_tready is high. A word passes through the
// magnitude, multiply and discriminant stages, 34 square-root stages,
// a setup stage, one divider stage per quotient bit, a saturation stage and
// the result queue write and read. The queue holds every word in flight, so
// req_tready drops only when 128 accepted words are not yet delivered.
`timescale 1ns / 1ps
module quadratic_root_solver import qrs_pkg::*; #(
   parameter int FRAC_BITS = QRS_FRAC_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [3*COEF_W-1:0]   req_tdata,  // coef_a, coef_b, coef_c
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [2*VAL_W-1:0]    rsp_tdata,  // first_value, second_value
   output logic [KIND_W:0]       rsp_tuser   // root_kind, overflow
);

   localparam int NUM_W   = NUM_MAG_W + FRAC_BITS;
   localparam int LATENCY = FRONT_STAGES + ROOT_W + 1 + NUM_W + 1;
   localparam int DEPTH   = 2 ** $clog2(LATENCY + 3);
   localparam int CW      = $clog2(DEPTH + 1);
   localparam int WORD_W  = 2 * VAL_W + KIND_W + 1;

   function automatic logic [COEF_W-1:0] mag_coef(logic signed [COEF_W-1:0] v);
      logic [COEF_W-1:0] u;
      u = v;
      return v[COEF_W-1] ? (~u + 1'b1) : u;
   endfunction

   function automatic logic [NUM_MAG_W-1:0] mag_num(logic signed [NSUM_W-1:0] v);
      logic [NSUM_W-1:0] u;
      u = v[NSUM_W-1] ? -v : v;
      return u[NUM_MAG_W-1:0];
   endfunction

   logic req_accept;
   logic rsp_accept;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_accept = rsp_tvalid && rsp_tready;

   // magnitudes
   logic                     s0_valid_ff;
   logic signed [COEF_W-1:0] s0_a_ff, s0_b_ff, s0_c_ff;
   logic [COEF_W-1:0]        s0_amag_ff, s0_bmag_ff, s0_cmag_ff;
   logic signed [COEF_W-1:0] a_w, b_w, c_w;

   assign a_w = req_tdata[COEF_W-1:0];
   assign b_w = req_tdata[2*COEF_W-1:COEF_W];
   assign c_w = req_tdata[3*COEF_W-1:2*COEF_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= req_accept;
      end
      s0_a_ff    <= a_w;
      s0_b_ff    <= b_w;
      s0_c_ff    <= c_w;
      s0_amag_ff <= mag_coef(a_w);
      s0_bmag_ff <= mag_coef(b_w);
      s0_cmag_ff <= mag_coef(c_w);
   end

   // products
   logic                     s1_valid_ff;
   logic signed [COEF_W-1:0] s1_a_ff, s1_b_ff, s1_c_ff;
   logic [2*COEF_W-1:0]      s1_sq_ff, s1_p_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s0_valid_ff;
      end
      s1_a_ff  <= s0_a_ff;
      s1_b_ff  <= s0_b_ff;
      s1_c_ff  <= s0_c_ff;
      s1_sq_ff <= s0_bmag_ff * s0_bmag_ff;
      s1_p_ff  <= s0_amag_ff * s0_cmag_ff;
   end

   // discriminant magnitude and sign
   logic [DISC_W-1:0] sq_w, p4_w, dsum_w, ddif1_w, ddif2_w, d_w;
   logic              sub_w, le_w;
   logic              s2_valid_ff;
   logic [DISC_W-1:0] s2_d_ff;
   front_type         s2_side_ff;
   front_type         side_in;

   always_comb begin
      sq_w    = {2'b00, s1_sq_ff};
      p4_w    = {s1_p_ff, 2'b00};
      dsum_w  = sq_w + p4_w;
      ddif1_w = sq_w - p4_w;
      ddif2_w = p4_w - sq_w;
      sub_w   = (s1_a_ff[COEF_W-1] == s1_c_ff[COEF_W-1]) && (s1_c_ff != '0);
      le_w    = (p4_w <= sq_w);
      d_w     = sub_w ? (le_w ? ddif1_w : ddif2_w) : dsum_w;
      side_in.a     = s1_a_ff;
      side_in.b     = s1_b_ff;
      side_in.c     = s1_c_ff;
      side_in.dneg  = sub_w && !le_w;
      side_in.dzero = (d_w == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_d_ff    <= d_w;
      s2_side_ff <= side_in;
   end

   logic              sr_valid;
   logic [ROOT_W-1:0] sr_root;
   front_type         sr_side;

   qrs_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid_ff),
      .in_rad    ({{(RAD_W-DISC_W){1'b0}}, s2_d_ff}),
      .in_side   (s2_side_ff),
      .out_valid (sr_valid),
      .out_root  (sr_root),
      .out_side  (sr_side)
   );

   // divider operands
   logic signed [NSUM_W-1:0] nb_w, sx_w, n1_w, n2_w;
   logic [NUM_MAG_W-1:0]     bmag_w;
   logic                     bpos_w, aneg_w;
   logic [DEN_W-1:0]         den2a_w;
   logic [NUM_MAG_W-1:0]     num1_in, num2_in;
   logic [DEN_W-1:0]         den1_in, den2_in;
   div_tag_type              tag1_in, tag2_in;
   logic                     s3_valid_ff;
   logic [NUM_MAG_W-1:0]     s3_num1_ff, s3_num2_ff;
   logic [DEN_W-1:0]         s3_den1_ff, s3_den2_ff;
   div_tag_type              s3_tag1_ff, s3_tag2_ff;

   always_comb begin
      nb_w    = -$signed({{(NSUM_W-COEF_W){sr_side.b[COEF_W-1]}}, sr_side.b});
      sx_w    = $signed({{(NSUM_W-ROOT_W){1'b0}}, sr_root});
      n1_w    = nb_w + sx_w;
      n2_w    = nb_w - sx_w;
      bmag_w  = NUM_MAG_W'(mag_coef(sr_side.b));
      bpos_w  = !sr_side.b[COEF_W-1] && (sr_side.b != '0);
      aneg_w  = sr_side.a[COEF_W-1];
      den2a_w = {mag_coef(sr_side.a), 1'b0};
      num1_in = '0;
      num2_in = '0;
      den1_in = DEN_W'(1);
      den2_in = DEN_W'(1);
      tag1_in = '{kind: KIND_ANY, neg: 1'b0};
      tag2_in = '{kind: KIND_ANY, neg: 1'b0};
      if (sr_side.a == '0) begin
         if (sr_side.b == '0) begin
            tag1_in.kind = (sr_side.c == '0) ? KIND_ANY : KIND_NONE;
         end else begin
            tag1_in.kind = KIND_LINEAR;
            num1_in      = NUM_MAG_W'(mag_coef(sr_side.c));
            den1_in      = {1'b0, mag_coef(sr_side.b)};
            tag1_in.neg  = (!sr_side.c[COEF_W-1] && (sr_side.c != '0))
                           != sr_side.b[COEF_W-1];
         end
      end else begin
         den1_in = den2a_w;
         den2_in = den2a_w;
         if (sr_side.dzero) begin
            tag1_in.kind = KIND_DOUBLE;
            num1_in      = bmag_w;
            num2_in      = bmag_w;
            tag1_in.neg  = bpos_w != aneg_w;
            tag2_in.neg  = bpos_w != aneg_w;
         end else if (sr_side.dneg) begin
            tag1_in.kind = KIND_COMPLEX;
            num1_in      = bmag_w;
            num2_in      = sr_root;
            tag1_in.neg  = bpos_w != aneg_w;
         end else begin
            tag1_in.kind = KIND_TWO;
            num1_in      = mag_num(n1_w);
            num2_in      = mag_num(n2_w);
            tag1_in.neg  = n1_w[NSUM_W-1] != aneg_w;
            tag2_in.neg  = n2_w[NSUM_W-1] != aneg_w;
         end
      end
      tag2_in.kind = tag1_in.kind;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= sr_valid;
      end
      s3_num1_ff <= num1_in;
      s3_num2_ff <= num2_in;
      s3_den1_ff <= den1_in;
      s3_den2_ff <= den2_in;
      s3_tag1_ff <= tag1_in;
      s3_tag2_ff <= tag2_in;
   end

   logic                    d1_valid, d2_valid, d1_ovf, d2_ovf;
   logic signed [VAL_W-1:0] d1_value, d2_value;
   div_tag_type             d1_tag, d2_tag;

   qrs_div #(.FRAC_BITS(FRAC_BITS)) u_div_first (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid_ff),
      .in_num    (s3_num1_ff),
      .in_den    (s3_den1_ff),
      .in_tag    (s3_tag1_ff),
      .out_valid (d1_valid),
      .out_value (d1_value),
      .out_ovf   (d1_ovf),
      .out_tag   (d1_tag)
   );

   qrs_div #(.FRAC_BITS(FRAC_BITS)) u_div_second (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid_ff),
      .in_num    (s3_num2_ff),
      .in_den    (s3_den2_ff),
      .in_tag    (s3_tag2_ff),
      .out_valid (d2_valid),
      .out_value (d2_value),
      .out_ovf   (d2_ovf),
      .out_tag   (d2_tag)
   );

   logic [WORD_W-1:0] q_out;

   qrs_fifo #(.DEPTH(DEPTH), .WIDTH(WORD_W)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (d1_valid),
      .push_data ({d1_ovf | d2_ovf, d1_tag.kind, d2_value, d1_value}),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (q_out)
   );

   assign rsp_tdata = q_out[2*VAL_W-1:0];
   assign rsp_tuser = q_out[WORD_W-1:2*VAL_W];

   // words accepted and not yet delivered
   logic [CW-1:0] pending_ff;
   logic [CW-1:0] pending_in;

   assign pending_in = pending_ff + CW'(req_accept) - CW'(rsp_accept);
   assign req_tready = (pending_ff < CW'(DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      (d1_valid == d2_valid) && (!d1_valid || (d1_tag.kind == d2_tag.kind)))
      else $error("divider lanes out of step");

   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= CW'(DEPTH))
      else $error("more words in flight than the queue holds");

endmodule

>>> hdl/qrs_sqrt.sv
// Pipelined integer floor square root, one root bit per stage.
`timescale 1ns / 1ps
module qrs_sqrt import qrs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [RAD_W-1:0]  in_rad,
   input  front_type         in_side,
   output logic              out_valid,
   output logic [ROOT_W-1:0] out_root,
   output front_type         out_side
);

   logic [ROOT_W-1:0] vld_ff;
   logic [RAD_W-1:0]  rad_ff  [ROOT_W];
   logic [SREM_W-1:0] rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   front_type         side_ff [ROOT_W];

   for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
      logic              vld_d;
      logic [RAD_W-1:0]  rad_d;
      logic [SREM_W-1:0] rem_d;
      logic [ROOT_W-1:0] root_d;
      front_type         side_d;
      logic [SREM_W-1:0] rem_t;
      logic [SREM_W-1:0] trial;
      logic              take;

      if (j == 0) begin : g_first
         assign vld_d  = in_valid;
         assign rad_d  = in_rad;
         assign rem_d  = '0;
         assign root_d = '0;
         assign side_d = in_side;
      end else begin : g_next
         assign vld_d  = vld_ff[j-1];
         assign rad_d  = rad_ff[j-1];
         assign rem_d  = rem_ff[j-1];
         assign root_d = root_ff[j-1];
         assign side_d = side_ff[j-1];
      end

      assign rem_t = {rem_d[SREM_W-3:0], rad_d[RAD_W-1:RAD_W-2]};
      assign trial = {{(SREM_W-ROOT_W-2){1'b0}}, root_d, 2'b01};
      assign take  = (rem_t >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else begin
            vld_ff[j] <= vld_d;
         end
         rad_ff[j]  <= {rad_d[RAD_W-3:0], 2'b00};
         rem_ff[j]  <= take ? (rem_t - trial) : rem_t;
         root_ff[j] <= {root_d[ROOT_W-2:0], take};
         side_ff[j] <= side_d;
      end
   end

   assign out_valid = vld_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (rem_ff[ROOT_W-1] <= SREM_W'({out_root, 1'b0})))
      else $error("square root remainder above twice the root");

   a_root_range: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> !out_root[ROOT_W-1])
      else $error("square root wider than the discriminant allows");

endmodule

>>> hdl/qrs_div.sv
// Pipelined restoring divider with sign and 32-bit saturation on the quotient.
`timescale 1ns / 1ps
module qrs_div import qrs_pkg::*; #(
   parameter int FRAC_BITS = QRS_FRAC_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic [NUM_MAG_W-1:0]    in_num,
   input  logic [DEN_W-1:0]        in_den,
   input  div_tag_type             in_tag,
   output logic                    out_valid,
   output logic signed [VAL_W-1:0] out_value,
   output logic                    out_ovf,
   output div_tag_type             out_tag
);

   localparam int NUM_W = NUM_MAG_W + FRAC_BITS;

   logic [NUM_W-1:0] vld_ff;
   logic [NUM_W-1:0] qn_ff  [NUM_W];
   logic [DEN_W-1:0] rem_ff [NUM_W];
   logic [DEN_W-1:0] den_ff [NUM_W];
   div_tag_type      tag_ff [NUM_W];

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic             vld_d;
      logic [NUM_W-1:0] qn_d;
      logic [DEN_W-1:0] rem_d;
      logic [DEN_W-1:0] den_d;
      div_tag_type      tag_d;
      logic [DEN_W:0]   rem_t;
      logic [DEN_W:0]   rem_s;
      logic             take;

      if (k == 0) begin : g_first
         assign vld_d = in_valid;
         assign qn_d  = {in_num, {FRAC_BITS{1'b0}}};
         assign rem_d = '0;
         assign den_d = in_den;
         assign tag_d = in_tag;
      end else begin : g_next
         assign vld_d = vld_ff[k-1];
         assign qn_d  = qn_ff[k-1];
         assign rem_d = rem_ff[k-1];
         assign den_d = den_ff[k-1];
         assign tag_d = tag_ff[k-1];
      end

      assign rem_t = {rem_d, qn_d[NUM_W-1]};
      assign take  = (rem_t >= {1'b0, den_d});
      assign rem_s = rem_t - {1'b0, den_d};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_d;
         end
         qn_ff[k]  <= {qn_d[NUM_W-2:0], take};
         rem_ff[k] <= take ? rem_s[DEN_W-1:0] : rem_t[DEN_W-1:0];
         den_ff[k] <= den_d;
         tag_ff[k] <= tag_d;
      end
   end

   logic [NUM_W-1:0]        q_w;
   logic                    hi_nz_w;
   logic signed [VAL_W-1:0] value_in;
   logic                    ovf_in;
   logic                    out_valid_ff;
   logic signed [VAL_W-1:0] out_value_ff;
   logic                    out_ovf_ff;
   div_tag_type             out_tag_ff;

   assign q_w     = qn_ff[NUM_W-1];
   assign hi_nz_w = |q_w[NUM_W-1:VAL_W];

   always_comb begin
      value_in = q_w[VAL_W-1:0];
      ovf_in   = 1'b0;
      if (!tag_ff[NUM_W-1].neg) begin
         if (hi_nz_w || q_w[VAL_W-1]) begin
            value_in = {1'b0, {(VAL_W-1){1'b1}}};
            ovf_in   = 1'b1;
         end
      end else begin
         if (hi_nz_w || (q_w[VAL_W-1] && (|q_w[VAL_W-2:0]))) begin
            value_in = {1'b1, {(VAL_W-1){1'b0}}};
            ovf_in   = 1'b1;
         end else begin
            value_in = -$signed(q_w[VAL_W-1:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= vld_ff[NUM_W-1];
      end
      out_value_ff <= value_in;
      out_ovf_ff   <= ovf_in;
      out_tag_ff   <= tag_ff[NUM_W-1];
   end

   assign out_valid = out_valid_ff;
   assign out_value = out_value_ff;
   assign out_ovf   = out_ovf_ff;
   assign out_tag   = out_tag_ff;

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NUM_W-1] |-> (rem_ff[NUM_W-1] < den_ff[NUM_W-1]))
      else $error("divider remainder not below divisor");

endmodule

>>> hdl/qrs_fifo.sv
// Result queue with registered read, sized to cover every word in flight.
`timescale 1ns / 1ps
module qrs_fifo #(
   parameter int DEPTH = 128,
   parameter int WIDTH = 68
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   localparam int AW = $clog2(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff;
   logic [AW-1:0]    rd_ptr_ff;
   logic [AW:0]      count_ff;
   logic [AW:0]      count_in;
   logic             out_valid_ff;
   logic [WIDTH-1:0] out_data_ff;
   logic             load;

   assign load     = (count_ff != '0) && (!out_valid_ff || out_ready);
   assign count_in = count_ff + (AW+1)'(push) - (AW+1)'(load);

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
      if (load) begin
         out_data_ff <= mem_ff[rd_ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (load) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
         if (load) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < (AW+1)'(DEPTH)))
      else $error("result queue written while full");

endmodule
